// ===== src/mspe_pkg.sv =====
// Package of shared types and constants for the mix saturate peak envelope unit.
package mspe_pkg;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_SHIFT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO_MODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_SHIFT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_MIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_MAX   = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [2:0]  GAIN_SHIFT_RST  = 3'd1;
    localparam logic        STEREO_MODE_RST = 1'b0;
    localparam logic [3:0]  QUIET_SHIFT_RST = 4'd4;
    localparam logic [15:0] QUIET_MIN_RST   = 16'd32;
    localparam logic [15:0] QUIET_MAX_RST   = 16'd256;

    // Envelope decay per block is env >> DECAY_SHIFT.
    localparam int unsigned DECAY_SHIFT = 5;

    // Signed 16-bit output range.
    localparam logic signed [15:0] SAT_HI = 16'sh7FFF;
    localparam logic signed [15:0] SAT_LO = 16'sh8000;

    typedef struct packed {
        logic signed [31:0] mix_left;
        logic signed [31:0] mix_right;
        logic               last_in_block;
    } mspe_in_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic [31:0]        clip_total;
        logic               level_valid;
        logic [15:0]        quiet_level;
        logic [15:0]        peak_envelope_out;
        logic [15:0]        max_peak;
    } mspe_out_t;

endpackage

// ===== src/mix_saturate_peak_envelope_unit.sv =====
// An accepted input transaction's result is registered directly into the output register.
// Throughput: one transaction per cycle; input ready drops only while a result is held by
// the output side. The peak and clip state update in the cycle the transaction is accepted.
// Reset (aresetn low, synchronous) clears the output valid, peaks, envelope and clip count,
// and returns the configuration registers to their defaults.
module mix_saturate_peak_envelope_unit
    import mspe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  mspe_in_t               s_payload,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mspe_out_t              m_payload
);

    logic [2:0]  gain_shift_reg;
    logic        stereo_mode_reg;
    logic [3:0]  quiet_shift_reg;
    logic [15:0] quiet_min_reg;
    logic [15:0] quiet_max_reg;

    logic [15:0] block_peak_reg,    block_peak_next;
    logic [15:0] peak_envelope_reg, peak_envelope_next;
    logic [15:0] all_time_peak_reg, all_time_peak_next;
    logic [31:0] clip_counter_reg,  clip_counter_next;

    logic      m_valid_reg;
    mspe_out_t m_payload_reg, m_payload_next;

    logic              accept;
    logic signed [15:0] sat_left;
    logic signed [15:0] sat_right;
    logic              clip_left;
    logic              clip_right;
    logic [15:0]       abs_left;
    logic [15:0]       peak_now;
    logic [15:0]       env_upd;
    logic [15:0]       quiet_raw;
    logic [15:0]       quiet_clamped;

    mspe_gain_sat u_sat_left (
        .sample  (s_payload.mix_left),
        .shift   (gain_shift_reg),
        .result  (sat_left),
        .clipped (clip_left)
    );

    mspe_gain_sat u_sat_right (
        .sample  (s_payload.mix_right),
        .shift   (gain_shift_reg),
        .result  (sat_right),
        .clipped (clip_right)
    );

    // The output register frees up when it is empty or being drained this cycle.
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        abs_left = sat_left[15] ? 16'(~sat_left + 16'sd1) : 16'(sat_left);
        peak_now = (abs_left > block_peak_reg) ? abs_left : block_peak_reg;

        // Instant attack, otherwise a fractional decay.
        if (peak_now > peak_envelope_reg) begin
            env_upd = peak_now;
        end else begin
            env_upd = peak_envelope_reg - (peak_envelope_reg >> DECAY_SHIFT);
        end

        // The lower clamp is checked first, so it wins for levels below it when the limits cross.
        quiet_raw = env_upd >> quiet_shift_reg;
        if (quiet_raw < quiet_min_reg) begin
            quiet_clamped = quiet_min_reg;
        end else if (quiet_raw > quiet_max_reg) begin
            quiet_clamped = quiet_max_reg;
        end else begin
            quiet_clamped = quiet_raw;
        end

        clip_counter_next = clip_counter_reg + 32'(clip_left)
                          + 32'(stereo_mode_reg & clip_right);

        if (s_payload.last_in_block) begin
            block_peak_next    = '0;
            peak_envelope_next = env_upd;
            all_time_peak_next = (peak_now > all_time_peak_reg) ? peak_now : all_time_peak_reg;
        end else begin
            block_peak_next    = peak_now;
            peak_envelope_next = peak_envelope_reg;
            all_time_peak_next = all_time_peak_reg;
        end

        m_payload_next.out_left    = sat_left;
        m_payload_next.out_right   = stereo_mode_reg ? sat_right : sat_left;
        m_payload_next.clip_total  = clip_counter_next;
        m_payload_next.level_valid = s_payload.last_in_block;
        if (s_payload.last_in_block) begin
            m_payload_next.quiet_level       = quiet_clamped;
            m_payload_next.peak_envelope_out = env_upd;
            m_payload_next.max_peak          = all_time_peak_next;
        end else begin
            m_payload_next.quiet_level       = '0;
            m_payload_next.peak_envelope_out = '0;
            m_payload_next.max_peak          = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_shift_reg  <= GAIN_SHIFT_RST;
            stereo_mode_reg <= STEREO_MODE_RST;
            quiet_shift_reg <= QUIET_SHIFT_RST;
            quiet_min_reg   <= QUIET_MIN_RST;
            quiet_max_reg   <= QUIET_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN_SHIFT:  gain_shift_reg  <= cfg_wdata[2:0];
                REG_STEREO_MODE: stereo_mode_reg <= cfg_wdata[0];
                REG_QUIET_SHIFT: quiet_shift_reg <= cfg_wdata[3:0];
                REG_QUIET_MIN:   quiet_min_reg   <= cfg_wdata[15:0];
                REG_QUIET_MAX:   quiet_max_reg   <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_peak_reg    <= '0;
            peak_envelope_reg <= '0;
            all_time_peak_reg <= '0;
            clip_counter_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                block_peak_reg    <= block_peak_next;
                peak_envelope_reg <= peak_envelope_next;
                all_time_peak_reg <= all_time_peak_next;
                clip_counter_reg  <= clip_counter_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_payload_reg <= m_payload_next;
        end
    end

endmodule

// ===== src/mspe_gain_sat.sv =====
// Gain shift of one mixed sample followed by saturation to signed 16 bits.
module mspe_gain_sat
    import mspe_pkg::*;
(
    input  logic signed [31:0] sample,
    input  logic [2:0]         shift,
    output logic signed [15:0] result,
    output logic               clipped
);

    // A 32-bit sample shifted by up to seven bits fits in 39 bits; 40 leaves margin.
    localparam int unsigned WIDE_W = 40;

    logic signed [WIDE_W-1:0] wide;
    logic signed [WIDE_W-1:0] hi_wide;
    logic signed [WIDE_W-1:0] lo_wide;
    logic                     over_hi;
    logic                     under_lo;

    assign hi_wide  = WIDE_W'(SAT_HI);
    assign lo_wide  = WIDE_W'(SAT_LO);
    assign wide     = WIDE_W'(sample) <<< shift;
    assign over_hi  = wide > hi_wide;
    assign under_lo = wide < lo_wide;
    assign clipped  = over_hi | under_lo;

    always_comb begin
        if (over_hi) begin
            result = SAT_HI;
        end else if (under_lo) begin
            result = SAT_LO;
        end else begin
            result = wide[15:0];
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the mix saturate peak envelope unit.
module testbench;
    import mspe_pkg::*;

    localparam int unsigned ENV_DECAY = 5;
    localparam int unsigned STALL_LIMIT = 1000;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    mspe_in_t               s_payload = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    mspe_out_t              m_payload;

    // Shadow copy of the registers and the tracking state.
    logic [2:0]  gain_shift  = GAIN_SHIFT_RST;
    logic        stereo_mode = STEREO_MODE_RST;
    logic [3:0]  quiet_shift = QUIET_SHIFT_RST;
    logic [15:0] quiet_min   = QUIET_MIN_RST;
    logic [15:0] quiet_max   = QUIET_MAX_RST;
    logic [15:0] block_peak    = '0;
    logic [15:0] envelope      = '0;
    logic [15:0] all_time_peak = '0;
    logic [31:0] clip_count    = '0;

    mspe_out_t   limiter_outputs_due[$];
    mspe_out_t   due_out;
    int unsigned mismatch_count = 0;
    int unsigned samples_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned block_ends     = 0;
    int unsigned stall_cycles   = 0;
    bit          sender_idle    = 1'b1;
    bit          receiver_idle  = 1'b1;
    int unsigned receiver_hold  = 0;

    mix_saturate_peak_envelope_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Shift in wide precision, then clamp to 16 bits and count the clamp.
    function automatic logic signed [15:0] gain_clamp(input logic signed [31:0] raw);
        logic signed [63:0] wide;
        wide = 64'(raw);
        wide = wide <<< gain_shift;
        if (wide > 64'(SAT_HI)) begin
            clip_count++;
            return SAT_HI;
        end
        if (wide < 64'(SAT_LO)) begin
            clip_count++;
            return SAT_LO;
        end
        return wide[15:0];
    endfunction

    function automatic mspe_out_t limit_and_track(input mspe_in_t x);
        mspe_out_t   y;
        int          left_val;
        logic [15:0] mag;
        logic [15:0] level;
        y = '0;
        y.out_left  = gain_clamp(x.mix_left);
        y.out_right = stereo_mode ? gain_clamp(x.mix_right) : y.out_left;
        left_val = int'(y.out_left);
        mag = (left_val < 0) ? 16'(-left_val) : 16'(left_val);
        if (mag > block_peak) block_peak = mag;
        if (x.last_in_block) begin
            if (block_peak > all_time_peak) all_time_peak = block_peak;
            if (block_peak > envelope) envelope = block_peak;
            else envelope = envelope - (envelope >> ENV_DECAY);
            level = envelope >> quiet_shift;
            if (level < quiet_min) level = quiet_min;
            else if (level > quiet_max) level = quiet_max;
            y.level_valid       = 1'b1;
            y.quiet_level       = level;
            y.peak_envelope_out = envelope;
            y.max_peak          = all_time_peak;
            block_peak = '0;
        end
        y.clip_total = clip_count;
        return y;
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < 10)
                $display("MISMATCH result %0d %s: expected %h, got %h",
                         results_seen, fname, want, got);
            mismatch_count++;
        end
    endtask

    // Every output transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (limiter_outputs_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("MISMATCH unexpected result: %p", m_payload);
                mismatch_count++;
            end else begin
                due_out = limiter_outputs_due.pop_front();
                compare_field("out_left", 32'(due_out.out_left),
                              32'(m_payload.out_left));
                compare_field("out_right", 32'(due_out.out_right),
                              32'(m_payload.out_right));
                compare_field("clip_total", due_out.clip_total, m_payload.clip_total);
                compare_field("level_valid", 32'(due_out.level_valid),
                              32'(m_payload.level_valid));
                compare_field("quiet_level", 32'(due_out.quiet_level),
                              32'(m_payload.quiet_level));
                compare_field("peak_envelope_out", 32'(due_out.peak_envelope_out),
                              32'(m_payload.peak_envelope_out));
                compare_field("max_peak", 32'(due_out.max_peak),
                              32'(m_payload.max_peak));
                if (due_out.level_valid) block_ends++;
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Output side: a random stall before each result while receiver_idle is set, or a long hold on request.
    initial begin : result_sink
        int unsigned stall;
        forever begin
            if (receiver_hold != 0) stall = receiver_hold;
            else stall = receiver_idle ? $urandom_range(0, 7) : 0;
            receiver_hold = 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_sample(input logic signed [31:0] left, input logic signed [31:0] right,
                               input logic last);
        mspe_in_t    item;
        int unsigned gap;
        item.mix_left      = left;
        item.mix_right     = right;
        item.last_in_block = last;
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        limiter_outputs_due.push_back(limit_and_track(item));
        samples_sent++;
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (limiter_outputs_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        drain_outputs();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_GAIN_SHIFT:  gain_shift  = value[2:0];
            REG_STEREO_MODE: stereo_mode = value[0];
            REG_QUIET_SHIFT: quiet_shift = value[3:0];
            REG_QUIET_MIN:   quiet_min   = value;
            REG_QUIET_MAX:   quiet_max   = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Four in ten in-range values for the current gain, three in ten at the clamp edge, three in ten raw.
    function automatic logic signed [31:0] pick_sample();
        int unsigned sel;
        int          lim;
        logic signed [31:0] v;
        sel = $urandom_range(0, 9);
        lim = 32768 >> gain_shift;
        if (sel < 3) v = $urandom;
        else if (sel < 7) v = int'($urandom_range(0, 2 * lim - 1)) - lim;
        else if (sel == 7) v = lim - 2 + int'($urandom_range(0, 2));
        else v = -lim - 1 + int'($urandom_range(0, 2));
        return v;
    endfunction

    task automatic test_default_config();
        send_sample(32'sd0, 32'sd0, 1'b0);
        send_sample(32'sd16383, 32'sd5, 1'b0);
        send_sample(32'sd16384, -32'sd5, 1'b0);
        send_sample(-32'sd16384, 32'sd0, 1'b0);
        send_sample(-32'sd16385, 32'sd0, 1'b0);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sd1, -32'sd1, 1'b1);
    endtask

    task automatic test_stereo_right();
        write_reg(REG_STEREO_MODE, 16'd1);
        write_reg(REG_GAIN_SHIFT, 16'd0);
        send_sample(32'sd32767, -32'sd32768, 1'b0);
        send_sample(32'sd32768, -32'sd32769, 1'b0);
        send_sample(-32'sd1, 32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_GAIN_SHIFT, 16'd7);
        send_sample(32'sd255, -32'sd256, 1'b0);
        send_sample(32'sd256, -32'sd257, 1'b1);
        write_reg(REG_GAIN_SHIFT, 16'd5);
        send_sample(32'sd1023, 32'sd1024, 1'b1);
        write_reg(REG_GAIN_SHIFT, 16'd4);
        send_sample(-32'sd2048, 32'sd2047, 1'b1);
    endtask

    task automatic test_level_clamp();
        write_reg(REG_STEREO_MODE, 16'd0);
        write_reg(REG_GAIN_SHIFT, 16'd0);
        write_reg(REG_QUIET_SHIFT, 16'd0);
        write_reg(REG_QUIET_MIN, 16'd0);
        write_reg(REG_QUIET_MAX, 16'd65535);
        send_sample(32'sd32767, 32'sd3, 1'b1);
        write_reg(REG_QUIET_SHIFT, 16'd15);
        send_sample(32'sd100, 32'sd3, 1'b1);
        // Lower bound above upper bound: the lower bound wins for small levels.
        write_reg(REG_QUIET_SHIFT, 16'd4);
        write_reg(REG_QUIET_MIN, 16'd1000);
        write_reg(REG_QUIET_MAX, 16'd10);
        send_sample(32'sd20000, 32'sd0, 1'b1);
        write_reg(REG_QUIET_MIN, 16'd0);
        write_reg(REG_QUIET_MAX, 16'd0);
        send_sample(32'sd5000, 32'sd0, 1'b1);
    endtask

    task automatic send_blocks(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
            for (int unsigned i = 0; i < len; i++) begin
                // A few samples carry a random end marker to break the block shape.
                if ($urandom_range(0, 19) == 0)
                    send_sample(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
                else
                    send_sample(pick_sample(), pick_sample(), i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] lo_clamp;
        logic [15:0] hi_clamp;
        for (int unsigned phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin lo_clamp = 16'd0; hi_clamp = 16'd65535; end
                1: begin lo_clamp = 16'd65535; hi_clamp = 16'd0; end
                2: begin
                    lo_clamp = 16'($urandom_range(0, 300));
                    hi_clamp = 16'($urandom_range(0, 2000));
                end
                default: begin lo_clamp = 16'($urandom); hi_clamp = 16'($urandom); end
            endcase
            write_reg(REG_GAIN_SHIFT, (phase == 0) ? 16'd0 :
                      (phase == 1) ? 16'd7 : 16'($urandom_range(0, 7)));
            write_reg(REG_STEREO_MODE, 16'($urandom_range(0, 1)));
            write_reg(REG_QUIET_SHIFT, (phase == 0) ? 16'd0 :
                      (phase == 1) ? 16'd15 : 16'($urandom_range(0, 15)));
            write_reg(REG_QUIET_MIN, lo_clamp);
            write_reg(REG_QUIET_MAX, hi_clamp);
            sender_idle   = (phase % 4 != 0) && (phase % 4 != 2);
            receiver_idle = (phase % 4 != 1) && (phase % 4 != 2);
            send_blocks(120);
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // The output side holds off while samples keep coming, so the input stalls.
    task automatic test_output_stall();
        write_reg(REG_STEREO_MODE, 16'd1);
        sender_idle   = 1'b0;
        receiver_hold = 64;
        send_blocks(30);
        sender_idle = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_config();
        test_stereo_right();
        test_gain_extremes();
        test_level_clamp();
        test_output_stall();
        test_random_traffic();
        drain_outputs();
        repeat (4) @(posedge aclk);
        $display("Sent %0d samples and checked %0d results, %0d of them block ends.",
                 samples_sent, results_seen, block_ends);
        $display("Clamp events counted: %0d; peak since reset: %0d.",
                 clip_count, all_time_peak);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
